### rtl/core/plc_pkg.sv
package plc_pkg;

  // calibration table size
  localparam int MAX_POINTS = 6;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);

  // field widths
  localparam int CNT_W      = 3;
  localparam int SIGN_W     = 2;
  localparam int PIX_W      = 16;
  localparam int POS_W      = 32;
  localparam int POINT_W    = PIX_W + POS_W;
  localparam int HUND_W     = 32;
  localparam int TENTH_W    = 29;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POINT_W;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_SIGN = 3'd1;
  localparam int                   REG_POINT_BASE     = 2;

  // stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - HUND_W - TENTH_W;

  // datapath widths
  localparam int DIFF_W = PIX_W;              // segment width and offset, unsigned
  localparam int DQ_W   = POS_W + 1;
  localparam int PA_W   = POS_W + DIFF_W + 1;
  localparam int PB_W   = DQ_W + DIFF_W + 1;
  localparam int T_W    = PB_W + 1;
  localparam int MAG_W  = POS_W + DIFF_W;     // |t| < 2^32 * d

  // long division: quotient never exceeds 2^31
  localparam int DIV_Q_W    = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;

  // divide by ten through a reciprocal
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // pipeline stage positions
  localparam int ST_A      = 0;
  localparam int ST_B      = 1;
  localparam int ST_C      = 2;
  localparam int ST_D      = 3;
  localparam int ST_DIV0   = 4;
  localparam int ST_E      = ST_DIV0 + DIV_STAGES;
  localparam int ST_F      = ST_E + 1;
  localparam int NUM_STAGES = ST_F + 1;

  typedef struct packed {
    logic [DIFF_W-1:0]  rem;
    logic [DIV_Q_W-1:0] num;      // dividend low bits in, quotient out
    logic [DIFF_W-1:0]  den;
    logic               neg;
    logic               too_few;
  } plc_div_t;

endpackage

### rtl/core/piecewise_linear_calibration_unit.sv
// channel   direction  payload
// s_axis    in         tdata[15:0] pixel_coord
// m_axis    out        tdata[31:0] position_hundredth_mm, tdata[60:32] position_tenth_mm,
//                      tuser too_few_points
// cfg       in         cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// one item per cycle while m_axis takes them; an item passes stages a to d, the divider stages, e and f
// the pipeline length is set by the 32-bit long division, four quotient bits per stage over 8 stages
// stalls ripple back stage by stage, empty stages keep filling while m_axis waits
// rst_ni clears the valid bits and sets the configuration registers to their reset values
module piecewise_linear_calibration_unit import plc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] pixel_coord
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] position_hundredth_mm,
                                                 // [60:32] position_tenth_mm, zero above
  output logic                   m_axis_tuser,   // [0] too_few_points
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // configuration registers
  logic [CNT_W-1:0]   point_count_q;
  logic [SIGN_W-1:0]  direction_sign_q;
  logic [POINT_W-1:0] point_q [MAX_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q    <= '0;
      direction_sign_q <= SIGN_W'(1);
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_POINT_COUNT) begin
        point_count_q <= cfg_data_i[CNT_W-1:0];
      end else if (cfg_index_i == REG_DIRECTION_SIGN) begin
        direction_sign_q <= cfg_data_i[SIGN_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_POINT_BASE + i)) begin
          point_q[i] <= cfg_data_i;
        end
      end
    end
  end

  logic signed [PIX_W-1:0] px [MAX_POINTS];
  logic signed [POS_W-1:0] pq [MAX_POINTS];

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      px[i] = $signed(point_q[i][PIX_W-1:0]);
      pq[i] = $signed(point_q[i][POINT_W-1:PIX_W]);
    end
  end

  logic [CNT_W-1:0]      n_eff;
  logic                  too_few;
  logic [MAX_POINTS-1:0] last_oh;
  logic                  s_zero;
  logic                  s_neg;

  always_comb begin
    n_eff   = (point_count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count_q;
    too_few = (n_eff < CNT_W'(2));
    for (int i = 0; i < MAX_POINTS; i++) begin
      last_oh[i] = (n_eff == CNT_W'(i + 1));
    end
    s_zero = (direction_sign_q == '0);
    s_neg  = direction_sign_q[SIGN_W-1];
  end

  // valid bits and stall chain
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // stage a: compare against every point
  logic signed [PIX_W-1:0] a_x_q;
  logic [MAX_POINTS-1:0]   a_gt_q;
  logic [MAX_POINTS-1:0]   a_ge_q;
  logic signed [PIX_W-1:0] a_x_d;
  logic [MAX_POINTS-1:0]   a_gt_d;
  logic [MAX_POINTS-1:0]   a_ge_d;

  always_comb begin
    a_x_d = $signed(s_axis_tdata[PIX_W-1:0]);
    for (int i = 0; i < MAX_POINTS; i++) begin
      a_gt_d[i] = (a_x_d > px[i]);
      a_ge_d[i] = (a_x_d >= px[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_A]) begin
      a_x_q  <= a_x_d;
      a_gt_q <= a_gt_d;
      a_ge_q <= a_ge_d;
    end
  end

  // stage b: pick the segment or the clamp point
  logic signed [POS_W-1:0] b_q0_q, b_q0_d;
  logic signed [DQ_W-1:0]  b_dq_q, b_dq_d;
  logic [DIFF_W-1:0]       b_d_q, b_d_d;
  logic [DIFF_W-1:0]       b_r_q, b_r_d;
  logic                    b_few_q;

  logic [MAX_POINTS-1:0]   hi_oh;
  logic                    found;
  logic                    lo_clamp;
  logic                    hi_clamp;
  logic [PIX_W-1:0]        p0_raw, p1_raw;
  logic [POS_W-1:0]        q0_raw, q1_raw, qlast_raw;
  logic [PIX_W:0]          seg_w, seg_off;

  always_comb begin
    lo_clamp  = !a_gt_q[0];
    hi_clamp  = |(a_ge_q & last_oh);
    hi_oh     = '0;
    found     = 1'b0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (!found && (((CNT_W'(i + 1) < n_eff) && !a_gt_q[i]) || last_oh[i])) begin
        hi_oh[i] = 1'b1;
        found    = 1'b1;
      end
    end
    p0_raw    = '0;
    p1_raw    = '0;
    q0_raw    = '0;
    q1_raw    = '0;
    qlast_raw = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (hi_oh[i]) begin
        p1_raw = p1_raw | point_q[i][PIX_W-1:0];
        q1_raw = q1_raw | point_q[i][POINT_W-1:PIX_W];
      end
      if (last_oh[i]) begin
        qlast_raw = qlast_raw | point_q[i][POINT_W-1:PIX_W];
      end
    end
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (hi_oh[i+1]) begin
        p0_raw = p0_raw | point_q[i][PIX_W-1:0];
        q0_raw = q0_raw | point_q[i][POINT_W-1:PIX_W];
      end
    end
    seg_w   = (PIX_W+1)'($signed(p1_raw)) - (PIX_W+1)'($signed(p0_raw));
    seg_off = (PIX_W+1)'(a_x_q) - (PIX_W+1)'($signed(p0_raw));

    if (too_few) begin
      b_q0_d = '0;
      b_dq_d = '0;
      b_d_d  = DIFF_W'(1);
      b_r_d  = '0;
    end else if (lo_clamp) begin
      b_q0_d = pq[0];
      b_dq_d = '0;
      b_d_d  = DIFF_W'(1);
      b_r_d  = '0;
    end else if (hi_clamp) begin
      b_q0_d = $signed(qlast_raw);
      b_dq_d = '0;
      b_d_d  = DIFF_W'(1);
      b_r_d  = '0;
    end else begin
      b_q0_d = $signed(q0_raw);
      b_dq_d = DQ_W'($signed(q1_raw)) - DQ_W'($signed(q0_raw));
      b_d_d  = seg_w[DIFF_W-1:0];
      b_r_d  = seg_off[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_B]) begin
      b_q0_q  <= b_q0_d;
      b_dq_q  <= b_dq_d;
      b_d_q   <= b_d_d;
      b_r_q   <= b_r_d;
      b_few_q <= too_few;
    end
  end

  // stage c: the two products
  logic signed [PA_W-1:0] c_pa_q;
  logic signed [PB_W-1:0] c_pb_q;
  logic [DIFF_W-1:0]      c_d_q;
  logic                   c_few_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_C]) begin
      c_pa_q  <= b_q0_q * $signed({1'b0, b_d_q});
      c_pb_q  <= b_dq_q * $signed({1'b0, b_r_q});
      c_d_q   <= b_d_q;
      c_few_q <= b_few_q;
    end
  end

  // stage d: sum, sign and magnitude for the divider
  logic signed [T_W-1:0] t_sum;
  logic [T_W-1:0]        t_abs;
  plc_div_t              d_q, d_d;

  always_comb begin
    t_sum     = T_W'(c_pa_q) + T_W'(c_pb_q);
    t_abs     = t_sum[T_W-1] ? T_W'(-t_sum) : T_W'(t_sum);
    if (s_zero) begin
      t_abs = '0;
    end
    d_d.rem     = t_abs[MAG_W-1:DIV_Q_W];
    d_d.num     = t_abs[DIV_Q_W-1:0];
    d_d.den     = c_d_q;
    d_d.neg     = t_sum[T_W-1] ^ s_neg;
    d_d.too_few = c_few_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_D]) begin
      d_q <= d_d;
    end
  end

  plc_div_t div_res;

  plc_div u_div (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: DIV_STAGES]),
    .div_i (d_q),
    .div_o (div_res)
  );

  // stage e: round half up on the quotient, tenths through the reciprocal
  logic [HUND_W:0]   e_hund_q, e_hund_d;
  logic [63:0]       e_prod_q, e_prod_d;
  logic              e_neg_q;
  logic              e_few_q;
  logic              round_up;
  logic [DIV_Q_W-1:0] quot_p5;

  always_comb begin
    round_up = ({div_res.rem, 1'b0} >= {1'b0, div_res.den});
    e_hund_d = (HUND_W+1)'(div_res.num) + (HUND_W+1)'(round_up);
    quot_p5  = div_res.num + DIV_Q_W'(5);
    e_prod_d = 64'(quot_p5) * 64'(RECIP_TEN);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_E]) begin
      e_hund_q <= e_hund_d;
      e_prod_q <= e_prod_d;
      e_neg_q  <= div_res.neg;
      e_few_q  <= div_res.too_few;
    end
  end

  // stage f: output register
  logic [HUND_W-1:0]  out_hund_q, out_hund_d;
  logic [TENTH_W-1:0] out_tenth_q, out_tenth_d;
  logic               out_few_q;
  logic [TENTH_W-1:0] tenth_mag;
  logic               hund_big;

  always_comb begin
    tenth_mag = e_prod_q[RECIP_SHIFT +: TENTH_W];
    hund_big  = e_hund_q[HUND_W] || e_hund_q[HUND_W-1];
    if (e_few_q) begin
      out_hund_d  = '0;
      out_tenth_d = '0;
    end else if (e_neg_q) begin
      out_hund_d  = (e_hund_q > (HUND_W+1)'({1'b1, {(HUND_W-1){1'b0}}}))
                    ? {1'b1, {(HUND_W-1){1'b0}}} : HUND_W'(-e_hund_q);
      out_tenth_d = TENTH_W'(-tenth_mag);
    end else begin
      // positive overflow saturates
      out_hund_d  = hund_big ? {1'b0, {(HUND_W-1){1'b1}}} : e_hund_q[HUND_W-1:0];
      out_tenth_d = tenth_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_F]) begin
      out_hund_q  <= out_hund_d;
      out_tenth_q <= out_tenth_d;
      out_few_q   <= e_few_q;
    end
  end

  assign m_axis_tvalid = valid_q[ST_F];
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_tenth_q, out_hund_q};
  assign m_axis_tuser  = out_few_q;

endmodule

### rtl/core/plc_div.sv
module plc_div import plc_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  plc_div_t              div_i,
  output plc_div_t              div_o
);

  function automatic plc_div_t div_step(plc_div_t s);
    plc_div_t          r;
    logic [DIFF_W:0]   part;
    logic [DIFF_W:0]   diff;
    r = s;
    for (int k = 0; k < DIV_STEP; k++) begin
      part  = {r.rem, r.num[DIV_Q_W-1]};
      diff  = part - {1'b0, r.den};
      r.num = {r.num[DIV_Q_W-2:0], 1'b0};
      if (!diff[DIFF_W]) begin
        r.rem    = diff[DIFF_W-1:0];
        r.num[0] = 1'b1;
      end else begin
        r.rem = part[DIFF_W-1:0];
      end
    end
    return r;
  endfunction

  plc_div_t stage_in [DIV_STAGES];
  plc_div_t stage_q  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign stage_in[j] = div_i;
    end else begin : g_next
      assign stage_in[j] = stage_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        stage_q[j] <= div_step(stage_in[j]);
      end
    end
  end

  assign div_o = stage_q[DIV_STAGES-1];

endmodule

### rtl/core/plc_checker.sv
module plc_checker import plc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // too few points gives zero positions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[HUND_W+TENTH_W-1:0] == '0)
    else $error("too_few_points item with non-zero position");

  // padding above the tenths field stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:HUND_W+TENTH_W] == '0)
    else $error("tdata padding not zero");

  // a non-negative hundredths value never pairs with a negative tenths value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[HUND_W-1] |-> !m_axis_tdata[HUND_W+TENTH_W-1])
    else $error("sign of tenths disagrees with hundredths");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

endmodule

bind piecewise_linear_calibration_unit plc_checker u_plc_checker (.*);

### bench/tb_piecewise_linear_calibration_unit.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_calibration_unit;
  import plc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int SINK_HOLD     = 300;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int QUIET_PHASE   = 3;
  localparam int HOLD_PHASE    = 5;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [HUND_W-1:0]  hund;
    logic [TENTH_W-1:0] tenth;
    logic               few;
  } position_t;

  typedef enum logic [2:0] {
    SETUP_RESET,
    SETUP_BASIC,
    SETUP_EXTREME,
    SETUP_NEG_MIN,
    SETUP_SIGN_M2,
    SETUP_SIGN_ZERO,
    SETUP_ONE_POINT,
    SETUP_UNSORTED
  } setup_e;

  typedef struct packed {
    setup_e           setup;
    logic [PIX_W-1:0] coord;
    logic             typed;
    position_t        want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 28;

  // typed rows carry their result, the others go through the predictor
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{SETUP_RESET,     16'sd0,      1'b1, '{32'sd0, 29'sd0, 1'b1}},
    '{SETUP_RESET,     16'h8000,    1'b1, '{32'sd0, 29'sd0, 1'b1}},
    '{SETUP_RESET,     16'h7FFF,    1'b1, '{32'sd0, 29'sd0, 1'b1}},
    '{SETUP_BASIC,     16'h8000,    1'b1, '{-32'sd5000, -29'sd500, 1'b0}},
    '{SETUP_BASIC,     -16'sd1600,  1'b1, '{-32'sd5000, -29'sd500, 1'b0}},
    '{SETUP_BASIC,     16'h7FFF,    1'b1, '{32'sd100000, 29'sd10000, 1'b0}},
    '{SETUP_BASIC,     16'sd16000,  1'b1, '{32'sd100000, 29'sd10000, 1'b0}},
    '{SETUP_BASIC,     -16'sd800,   1'b0, '0},
    '{SETUP_BASIC,     16'sd0,      1'b0, '0},
    '{SETUP_BASIC,     16'sd800,    1'b0, '0},
    '{SETUP_BASIC,     16'sd8,      1'b0, '0},
    '{SETUP_BASIC,     16'sd1601,   1'b0, '0},
    '{SETUP_EXTREME,   16'h8000,    1'b1, '{32'h8000_0000, -29'sd214748365, 1'b0}},
    '{SETUP_EXTREME,   16'h7FFF,    1'b1, '{32'h7FFF_FFFF, 29'sd214748365, 1'b0}},
    '{SETUP_EXTREME,   -16'sd20000, 1'b0, '0},
    '{SETUP_EXTREME,   -16'sd1,     1'b0, '0},
    '{SETUP_EXTREME,   16'sd0,      1'b0, '0},
    '{SETUP_EXTREME,   16'sd12345,  1'b0, '0},
    '{SETUP_NEG_MIN,   16'h8000,    1'b1, '{32'h7FFF_FFFF, 29'sd214748365, 1'b0}},
    '{SETUP_NEG_MIN,   16'h7FFF,    1'b1, '{32'h8000_0001, -29'sd214748365, 1'b0}},
    '{SETUP_NEG_MIN,   16'sd50,     1'b0, '0},
    '{SETUP_SIGN_M2,   16'h7FFF,    1'b1, '{-32'sd50000, -29'sd5000, 1'b0}},
    '{SETUP_SIGN_M2,   16'sd4000,   1'b0, '0},
    '{SETUP_SIGN_ZERO, 16'sd1234,   1'b1, '{32'sd0, 29'sd0, 1'b0}},
    '{SETUP_ONE_POINT, -16'sd5,     1'b1, '{32'sd0, 29'sd0, 1'b1}},
    '{SETUP_UNSORTED,  16'sd1000,   1'b0, '0},
    '{SETUP_UNSORTED,  16'sd4000,   1'b0, '0},
    '{SETUP_UNSORTED,  -16'sd400,   1'b0, '0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // calibration registers as the block should hold them
  logic [CNT_W-1:0]   cal_count = '0;
  logic [SIGN_W-1:0]  cal_sign  = 2'd1;
  logic [POINT_W-1:0] cal_points [MAX_POINTS] = '{default: '0};

  logic signed [PIX_W-1:0] tbl_pix [MAX_POINTS];
  logic signed [POS_W-1:0] tbl_pos [MAX_POINTS];

  position_t pending_positions [$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  bit        src_gaps    = 1'b1;
  bit        snk_gaps    = 1'b1;
  bit        hold_req    = 1'b0;

  piecewise_linear_calibration_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint round_half_away(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned quot;
    mag  = (num < 0) ? longint'(-num) : num;
    quot = (2 * mag + longint'(den)) / (2 * longint'(den));
    return (num < 0) ? -longint'(quot) : longint'(quot);
  endfunction

  function automatic position_t predict_position(input logic [PIX_W-1:0] coord);
    position_t res;
    longint    pix [MAX_POINTS];
    longint    pos [MAX_POINTS];
    longint    x, s, t, d, hund, tenth;
    int        n, k;
    res = '0;
    n = (cal_count > MAX_POINTS) ? MAX_POINTS : int'(cal_count);
    if (n < 2) begin
      res.few = 1'b1;
      return res;
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      pix[i] = $signed(cal_points[i][PIX_W-1:0]);
      pos[i] = $signed(cal_points[i][POINT_W-1:PIX_W]);
    end
    x = $signed(coord);
    // sign register reduced to its sign
    s = cal_sign[1] ? -64'sd1 : (cal_sign[0] ? 64'sd1 : 64'sd0);
    if (x <= pix[0]) begin
      t = s * pos[0];
      d = 1;
    end else if (x >= pix[n-1]) begin
      t = s * pos[n-1];
      d = 1;
    end else begin
      k = 1;
      while (k < n - 1 && x > pix[k]) k++;
      d = pix[k] - pix[k-1];
      t = s * (pos[k-1] * d + (x - pix[k-1]) * (pos[k] - pos[k-1]));
    end
    hund = round_half_away(t, d);
    if (hund > 64'sd2147483647) hund = 64'sd2147483647;
    if (hund < -64'sd2147483648) hund = -64'sd2147483648;
    tenth = round_half_away(t, 10 * d);
    res.hund  = hund[HUND_W-1:0];
    res.tenth = tenth[TENTH_W-1:0];
    return res;
  endfunction

  // cfg_we_i is lowered by the caller once the last write is done
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_POINT_COUNT:    cal_count = value[CNT_W-1:0];
      REG_DIRECTION_SIGN: cal_sign  = value[SIGN_W-1:0];
      default:            cal_points[idx - REG_POINT_BASE] = value[POINT_W-1:0];
    endcase
  endtask

  task automatic load_table(input logic [CNT_W-1:0] count, input logic [SIGN_W-1:0] sign);
    cfg_write(REG_POINT_COUNT, CFG_DATA_W'(count));
    cfg_write(REG_DIRECTION_SIGN, CFG_DATA_W'(sign));
    for (int i = 0; i < MAX_POINTS; i++)
      cfg_write(CFG_IDX_W'(REG_POINT_BASE + i), {tbl_pos[i], tbl_pix[i]});
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setup(input setup_e setup);
    case (setup)
      SETUP_BASIC: begin
        tbl_pix = '{-16'sd1600, 16'sd0, 16'sd1600, 16'sd16000, 16'sd0, 16'sd0};
        tbl_pos = '{-32'sd5000, 32'sd0, 32'sd12345, 32'sd100000, 32'sd0, 32'sd0};
        load_table(3'd4, 2'd1);
      end
      SETUP_EXTREME: begin
        tbl_pix = '{16'h8000, -16'sd16000, -16'sd1, 16'sd0, 16'sd1, 16'h7FFF};
        tbl_pos = '{32'h8000_0000, -32'sd1000000, 32'sd7, 32'sd8, 32'sd9, 32'h7FFF_FFFF};
        load_table(3'd6, 2'd1);
      end
      SETUP_NEG_MIN: begin
        // negated minimum position saturates
        tbl_pix = '{16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        tbl_pos = '{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        load_table(3'd2, 2'd3);
      end
      SETUP_SIGN_M2: begin
        // count above the table size, sign register at its most negative
        tbl_pix = '{-16'sd3200, -16'sd1600, 16'sd0, 16'sd1600, 16'sd3200, 16'sd4800};
        tbl_pos = '{-32'sd3000, -32'sd1000, 32'sd0, 32'sd1000, 32'sd30000, 32'sd50000};
        load_table(3'd7, 2'd2);
      end
      SETUP_SIGN_ZERO: begin
        tbl_pix = '{-16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd0};
        tbl_pos = '{32'sd100, 32'sd200, 32'sd300, 32'sd0, 32'sd0, 32'sd0};
        load_table(3'd3, 2'd0);
      end
      SETUP_ONE_POINT: begin
        tbl_pix = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        tbl_pos = '{32'sd777, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        load_table(3'd1, 2'd1);
      end
      SETUP_UNSORTED: begin
        tbl_pix = '{16'sd0, -16'sd800, 16'sd3200, 16'sd1600, 16'sd4800, 16'sd0};
        tbl_pos = '{32'sd100, 32'sd200, -32'sd300, 32'sd400, 32'sd500, 32'sd0};
        load_table(3'd5, 2'd1);
      end
      default: ;
    endcase
  endtask

  // tvalid stays high from one item to the next unless a gap falls between
  task automatic send_coord(input logic [PIX_W-1:0] coord, input position_t want);
    if (src_gaps)
      while ($urandom_range(0, 99) < 6) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= coord;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_positions.push_back(want);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !snk_gaps || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    position_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_positions.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_positions.pop_front();
        if (m_axis_tdata[HUND_W-1:0] !== want.hund ||
            m_axis_tdata[HUND_W+TENTH_W-1:HUND_W] !== want.tenth ||
            m_axis_tuser !== want.few) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: hund exp %0d got %0d, tenth exp %0d got %0d, few exp %b got %b",
                     $signed(want.hund), $signed(m_axis_tdata[HUND_W-1:0]),
                     $signed(want.tenth), $signed(m_axis_tdata[HUND_W+TENTH_W-1:HUND_W]),
                     want.few, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    setup_e                  cur_setup;
    position_t               want;
    logic [PIX_W-1:0]        coord;
    logic signed [PIX_W-1:0] swap;
    logic [CNT_W-1:0]        count;
    int                      k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_setup = SETUP_RESET;
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      if (directed_rows[row].setup != cur_setup) begin
        drain();
        cur_setup = directed_rows[row].setup;
        apply_setup(cur_setup);
      end
      want = directed_rows[row].typed ? directed_rows[row].want
                                      : predict_position(directed_rows[row].coord);
      send_coord(directed_rows[row].coord, want);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      count = CNT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) count = CNT_W'($urandom_range(2, 6));
      for (int i = 0; i < MAX_POINTS; i++) begin
        tbl_pix[i] = PIX_W'($urandom);
        tbl_pos[i] = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                                 : POS_W'($urandom_range(0, 400000)) - 32'sd200000;
      end
      // mostly ascending tables, now and then left in random order
      if ($urandom_range(0, 3) != 0)
        for (int a = 0; a < MAX_POINTS - 1; a++)
          for (int b = 0; b < MAX_POINTS - 1 - a; b++)
            if (tbl_pix[b] > tbl_pix[b+1]) begin
              swap         = tbl_pix[b];
              tbl_pix[b]   = tbl_pix[b+1];
              tbl_pix[b+1] = swap;
            end
      load_table(count, SIGN_W'($urandom_range(0, 3)));
      src_gaps = (phase != QUIET_PHASE);
      snk_gaps = (phase != QUIET_PHASE);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        case ($urandom_range(0, 9))
          0: coord = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          1, 2, 3, 4: begin
            // close to a calibration point, on either side
            k = $urandom_range(0, MAX_POINTS - 1);
            coord = cal_points[k][PIX_W-1:0] + PIX_W'($urandom_range(0, 8)) - 16'd4;
          end
          default: coord = PIX_W'($urandom);
        endcase
        send_coord(coord, predict_position(coord));
      end
    end

    drain();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
